// ===== rtl/msei_pkg.sv =====
package msei_pkg;

   // Port widths
   localparam int REQ_TDATA_W = 176;
   localparam int REQ_TUSER_W = 4;
   localparam int RSP_TDATA_W = 128;
   localparam int RSP_TUSER_W = 3;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 16;

   // Register reset values
   localparam logic [15:0] DEADBAND_RST   = 16'd50;
   localparam logic [3:0]  FAIL_LIMIT_RST = 4'd4;
   localparam logic [15:0] MAX_GAP_RST    = 16'd5000;

   // Status word bit that flags a voltage sag
   localparam int SAG_BIT = 1;

   // Energy kept as whole Wh plus a uWh remainder below one Wh.
   // 2^64 uWh = WH_MAX Wh + WRAP_REM uWh.
   localparam logic [44:0] WH_MAX        = 45'd18446744073709;
   localparam logic [19:0] UWH_PER_WH    = 20'd1000000;
   localparam logic [19:0] WRAP_REM      = 20'd551616;
   localparam logic [19:0] WRAP_REM_LOAD = 20'd448384;  // UWH_PER_WH - WRAP_REM

   // floor(x / 18e6) = floor((x >> 7) / 140625), 27-bit dividend
   localparam logic [27:0] RECIP_Q = 28'd250199980;     // ceil(2^45 / 140625)
   localparam logic [24:0] DIV_Q   = 25'd18000000;
   // floor(r / 18) = floor((r >> 1) / 9), 24-bit dividend
   localparam logic [24:0] RECIP_9 = 25'd29826162;      // ceil(2^28 / 9)

   typedef enum logic [1:0] {
      FUNC_SAMPLE   = 2'd0,
      FUNC_PRESET   = 2'd1,
      FUNC_TAKE_SAG = 2'd2,
      FUNC_NOP      = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      CSR_DEADBAND   = 2'd0,
      CSR_FAIL_LIMIT = 2'd1,
      CSR_MAX_GAP    = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic        [15:0] voltage_cv;
      logic        [15:0] current_ma;
      logic signed [15:0] power_w;
      logic        [15:0] freq_chz;
      logic signed [15:0] power_factor_milli;
   } held_type;

   // Result fields fixed at the front of the pipe
   typedef struct packed {
      held_type held;
      logic     reading_valid;
      logic     faulted;
      logic     sag_event;
   } snap_type;

   // Energy preset carried down to the accumulator stage
   typedef struct packed {
      logic        load;
      logic [44:0] wh;
      logic [19:0] rem;
   } eop_type;

endpackage

// ===== rtl/meter_sample_scaler_energy_integrator.sv =====
// Pipeline from req word accepted to rsp_tvalid: input reg, product, quotient, remainder,
// remainder / 18, accumulate into the output reg.
// Throughput: 1 word per clock; all stages advance together, stalled only by rsp_tready.
// The reading state (stage 1) and the energy accumulator (Wh + uWh remainder, stage 5) are
// the only loops, and each closes within its own stage.
// Reset (synchronous, active high): pipe empty, energy, fail count, valid flag, sag latch
// and held reading cleared, config registers back to 50 mA / 4 / 5000 ms.
module meter_sample_scaler_energy_integrator
   import msei_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // config write port
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   // sample words
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // raw_current, raw_voltage, raw_power, raw_freq, raw_pf, elapsed_ms,
   // status_word, preset_wh, zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // func[1:0], read_ok, status_ok
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   // result words
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // voltage_cv, current_ma, power_w, freq_chz, power_factor_milli, total_wh, zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // reading_valid, faulted, sag_event
   output logic [RSP_TUSER_W-1:0] rsp_tuser
);

   // ---------------------------------------------------------------- config
   logic [15:0] deadband_ff;
   logic [3:0]  fail_limit_ff;
   logic [15:0] max_gap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff   <= DEADBAND_RST;
         fail_limit_ff <= FAIL_LIMIT_RST;
         max_gap_ff    <= MAX_GAP_RST;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_addr))
            CSR_DEADBAND:   deadband_ff   <= csr_wdata;
            CSR_FAIL_LIMIT: fail_limit_ff <= csr_wdata[3:0];
            CSR_MAX_GAP:    max_gap_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- pipe control
   // One enable for every stage: the pipe moves when the output register is free.
   logic adv;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff, rsp_valid_ff;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= req_tvalid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         rsp_valid_ff <= s5_valid_ff;
      end
   end

   // ---------------------------------------------------------------- stage 1: input reg
   func_type    s1_func_ff;
   logic        s1_read_ok_ff, s1_status_ok_ff;
   logic [15:0] s1_current_ff, s1_voltage_ff, s1_power_ff, s1_freq_ff, s1_pf_ff;
   logic [31:0] s1_elapsed_ff;
   logic [15:0] s1_status_ff;
   logic [44:0] s1_preset_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_func_ff      <= func_type'(req_tuser[1:0]);
         s1_read_ok_ff   <= req_tuser[2];
         s1_status_ok_ff <= req_tuser[3];
         s1_current_ff   <= req_tdata[15:0];
         s1_voltage_ff   <= req_tdata[31:16];
         s1_power_ff     <= req_tdata[47:32];
         s1_freq_ff      <= req_tdata[63:48];
         s1_pf_ff        <= req_tdata[79:64];
         s1_elapsed_ff   <= req_tdata[111:80];
         s1_status_ff    <= req_tdata[127:112];
         s1_preset_ff    <= req_tdata[172:128];
      end
   end

   // Reading state: updated as a word leaves stage 1
   logic [3:0] fail_ff, fail_in;
   logic       vflag_ff, vflag_in;
   logic       sag_ff, sag_in;
   held_type   held_ff, held_in;

   logic        sag_set, below, pos_power, integ, preset_over;
   logic [15:0] cur_db, pw_db, pf_conv;
   logic [14:0] prod_a;
   logic [15:0] prod_b;
   snap_type    s1_snap;
   eop_type     s1_eop;

   always_comb begin
      sag_set = (s1_func_ff == FUNC_SAMPLE) && s1_status_ok_ff && s1_status_ff[SAG_BIT];

      // deadband zeroes current and power together
      below  = s1_current_ff < deadband_ff;
      cur_db = below ? 16'd0 : s1_current_ff;
      pw_db  = below ? 16'd0 : s1_power_ff;

      // sign-magnitude to two's complement; negative zero comes out as 0
      pf_conv = s1_pf_ff[15] ? (16'd0 - {1'b0, s1_pf_ff[14:0]}) : {1'b0, s1_pf_ff[14:0]};

      pos_power = (pw_db != 16'd0) && !pw_db[15];
      integ     = (s1_elapsed_ff != 32'd0) && (s1_elapsed_ff < {16'd0, max_gap_ff})
                  && pos_power;

      // preset above 2^64 uWh wraps once
      preset_over = s1_preset_ff > WH_MAX;

      sag_in   = sag_ff;
      fail_in  = fail_ff;
      vflag_in = vflag_ff;
      held_in  = held_ff;
      prod_a   = '0;
      prod_b   = '0;
      s1_eop   = '0;

      case (s1_func_ff)
         FUNC_SAMPLE: begin
            if (sag_set) sag_in = 1'b1;
            if (!s1_read_ok_ff) begin
               if (fail_ff < fail_limit_ff) fail_in = 4'(fail_ff + 4'd1);
               if (fail_in >= fail_limit_ff) vflag_in = 1'b0;
            end else begin
               fail_in                    = '0;
               vflag_in                   = 1'b1;
               held_in.voltage_cv         = s1_voltage_ff;
               held_in.current_ma         = cur_db;
               held_in.power_w            = pw_db;
               held_in.freq_chz           = s1_freq_ff;
               held_in.power_factor_milli = pf_conv;
               if (integ) begin
                  prod_a = pw_db[14:0];
                  prod_b = s1_elapsed_ff[15:0];
               end
            end
         end
         FUNC_PRESET: begin
            s1_eop.load = 1'b1;
            s1_eop.wh   = preset_over ? 45'(s1_preset_ff - WH_MAX - 45'd1) : s1_preset_ff;
            s1_eop.rem  = preset_over ? WRAP_REM_LOAD : 20'd0;
         end
         FUNC_TAKE_SAG: sag_in = 1'b0;
         default: ;
      endcase

      s1_snap.held          = held_in;
      s1_snap.reading_valid = vflag_in;
      s1_snap.faulted       = fail_in >= fail_limit_ff;
      s1_snap.sag_event     = sag_ff | sag_set;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fail_ff  <= '0;
         vflag_ff <= 1'b0;
         sag_ff   <= 1'b0;
         held_ff  <= '0;
      end else if (s1_valid_ff && adv) begin
         fail_ff  <= fail_in;
         vflag_ff <= vflag_in;
         sag_ff   <= sag_in;
         held_ff  <= held_in;
      end
   end

   // ---------------------------------------------------------------- stage 2: W*ms
   // increment = floor(5*W*ms / 18) uWh, split into Wh (q) and uWh (r) parts
   logic [30:0] s2_prod_ff;
   snap_type    s2_snap_ff, s3_snap_ff, s4_snap_ff, s5_snap_ff, rsp_snap_ff;
   eop_type     s2_eop_ff, s3_eop_ff, s4_eop_ff, s5_eop_ff;

   logic [33:0] s2_x;
   logic [54:0] s2_qm;

   always_comb begin
      s2_x  = ({3'd0, s2_prod_ff} << 2) + {3'd0, s2_prod_ff};
      s2_qm = {28'd0, s2_x[33:7]} * {27'd0, RECIP_Q};
   end

   // ---------------------------------------------------------------- stage 3/4: remainder
   logic [9:0]  s3_q_ff, s4_q_ff, s5_q_ff;
   logic [24:0] s3_x_ff, s4_r_ff;
   logic [19:0] s5_r_ff;
   logic [34:0] s3_qd;
   logic [48:0] s4_rm;

   always_comb begin
      s3_qd = {25'd0, s3_q_ff} * {10'd0, DIV_Q};
      s4_rm = {25'd0, s4_r_ff[24:1]} * {24'd0, RECIP_9};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_prod_ff <= {16'd0, prod_a} * {15'd0, prod_b};
         s2_snap_ff <= s1_snap;
         s2_eop_ff  <= s1_eop;

         s3_q_ff    <= s2_qm[54:45];
         s3_x_ff    <= s2_x[24:0];
         s3_snap_ff <= s2_snap_ff;
         s3_eop_ff  <= s2_eop_ff;

         // remainder below 18e6 fits 25 bits, so the low bits suffice
         s4_q_ff    <= s3_q_ff;
         s4_r_ff    <= s3_x_ff - s3_qd[24:0];
         s4_snap_ff <= s3_snap_ff;
         s4_eop_ff  <= s3_eop_ff;

         s5_q_ff    <= s4_q_ff;
         s5_r_ff    <= s4_rm[47:28];
         s5_snap_ff <= s4_snap_ff;
         s5_eop_ff  <= s4_eop_ff;
      end
   end

   // ---------------------------------------------------------------- stage 5: accumulate
   logic [44:0] wh_ff, wh_in;
   logic [19:0] rem_ff, rem_in;
   logic [20:0] rem_sum;
   logic [19:0] rem_a;
   logic        carry, over;
   logic [45:0] wh_sum;
   logic [44:0] rsp_wh_ff;

   always_comb begin
      rem_sum = {1'b0, rem_ff} + {1'b0, s5_r_ff};
      carry   = rem_sum >= {1'b0, UWH_PER_WH};
      rem_a   = carry ? 20'(rem_sum - {1'b0, UWH_PER_WH}) : rem_sum[19:0];
      wh_sum  = {1'b0, wh_ff} + {36'd0, s5_q_ff} + {45'd0, carry};
      // reached 2^64 uWh: take it off once
      over    = (wh_sum > {1'b0, WH_MAX}) || ((wh_sum == {1'b0, WH_MAX}) && (rem_a >= WRAP_REM));

      wh_in  = wh_sum[44:0];
      rem_in = rem_a;
      if (over) begin
         if (rem_a >= WRAP_REM) begin
            rem_in = rem_a - WRAP_REM;
            wh_in  = 45'(wh_sum - {1'b0, WH_MAX});
         end else begin
            rem_in = rem_a + WRAP_REM_LOAD;
            wh_in  = 45'(wh_sum - {1'b0, WH_MAX} - 46'd1);
         end
      end
      if (s5_eop_ff.load) begin
         wh_in  = s5_eop_ff.wh;
         rem_in = s5_eop_ff.rem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wh_ff  <= '0;
         rem_ff <= '0;
      end else if (s5_valid_ff && adv) begin
         wh_ff  <= wh_in;
         rem_ff <= rem_in;
      end
   end

   // ---------------------------------------------------------------- output reg
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_snap_ff <= s5_snap_ff;
         rsp_wh_ff   <= wh_in;
      end
   end

   assign rsp_tdata = {3'd0,
                       rsp_wh_ff,
                       rsp_snap_ff.held.power_factor_milli,
                       rsp_snap_ff.held.freq_chz,
                       rsp_snap_ff.held.power_w,
                       rsp_snap_ff.held.current_ma,
                       rsp_snap_ff.held.voltage_cv};
   assign rsp_tuser = {rsp_snap_ff.sag_event, rsp_snap_ff.faulted, rsp_snap_ff.reading_valid};

   // ---------------------------------------------------------------- checks
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      rem_ff < UWH_PER_WH)
      else $error("uWh remainder out of range");

   a_energy_norm: assert property (@(posedge clock) disable iff (reset)
      (wh_ff < WH_MAX) || ((wh_ff == WH_MAX) && (rem_ff < WRAP_REM)))
      else $error("energy accumulator above 2^64 uWh");

   a_sag_take: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && adv && (s1_func_ff == FUNC_TAKE_SAG)) |=> !sag_ff)
      else $error("sag latch not cleared by take");

endmodule
